FILE: hdl/cpu8080_execute_subset_core_assert.svh
// Assertion macros for the 8080 execute subset core.
`ifndef CPU8080_EXECUTE_SUBSET_CORE_ASSERT_SVH
`define CPU8080_EXECUTE_SUBSET_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define C8E_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define C8E_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: hdl/c8e_pkg.sv
// ----------------------------------------------------------------------------
// c8e_pkg
// Types, constants and helpers shared by the 8080 execute subset core.
// ----------------------------------------------------------------------------
package c8e_pkg;

  localparam logic [15:0] RAM_LOW_RST  = 16'h2000;
  localparam logic [15:0] RAM_HIGH_RST = 16'h3fff;
  localparam logic [15:0] RST6_VEC     = 16'h0030;
  localparam logic [15:0] RST7_VEC     = 16'h0038;

  localparam logic [0:0] CFG_RAM_LOW  = 1'b0;
  localparam logic [0:0] CFG_RAM_HIGH = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_WIN   = 2'd1;
  localparam logic [1:0] ST_UNIMP = 2'd2;

  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] imm_low;
    logic [7:0] imm_high;
    logic [7:0] operand_byte;
    logic [7:0] stack_low;
    logic [7:0] stack_high;
  } in_item_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic [15:0] stack_ptr;
    logic [7:0]  acc_out;
    logic [15:0] pair_bc;
    logic [15:0] pair_de;
    logic [15:0] pair_hl;
    logic [4:0]  flag_bits;
    logic [1:0]  write_count;
    logic [15:0] write_addr;
    logic [7:0]  write_low;
    logic [7:0]  write_high;
    logic [1:0]  status;
  } out_item_t;

  // Architectural state.
  typedef struct packed {
    logic [7:0]  a;
    logic [15:0] bc;
    logic [15:0] de;
    logic [15:0] hl;
    logic [15:0] sp;
    logic [15:0] pc;
    logic [4:0]  f;
  } arch_t;

  // Raw store request from decode, before the window check.
  typedef struct packed {
    logic [1:0]  cnt;
    logic [15:0] addr;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic        unimp;
  } store_t;

  function automatic logic even_par(input logic [7:0] v);
    even_par = ~^v;
  endfunction

  // Z, S, P from a byte; carry and aux carry kept from f.
  function automatic logic [4:0] zsp(input logic [7:0] v, input logic [4:0] f);
    zsp = {f[4], f[3], even_par(v), v[7], (v == 8'h00)};
  endfunction

endpackage

FILE: hdl/c8e_exec.sv
// ----------------------------------------------------------------------------
// c8e_exec
// Combinational decode and execute of one instruction against the state.
// ----------------------------------------------------------------------------
module c8e_exec (
  input  c8e_pkg::in_item_t item,
  input  c8e_pkg::arch_t    cur,
  output c8e_pkg::arch_t    nxt,
  output c8e_pkg::store_t   st
);

  logic [7:0]  op;
  logic [7:0]  src;
  logic [15:0] imm16;
  logic [15:0] stk;
  logic [15:0] pc1, pc2, pc3;
  logic        pos;
  logic        push;
  logic [8:0]  sum;
  logic [16:0] sum16;
  logic [7:0]  t8;
  logic [15:0] sp_dn;

  always_comb begin
    op    = item.opcode;
    imm16 = {item.imm_high, item.imm_low};
    stk   = {item.stack_high, item.stack_low};
    pc1   = cur.pc + 16'd1;
    pc2   = cur.pc + 16'd2;
    pc3   = cur.pc + 16'd3;
    pos   = ~cur.f[1];
    sp_dn = cur.sp - 16'd2;
    case (op[2:0])
      3'd0: src = cur.bc[15:8];
      3'd1: src = cur.bc[7:0];
      3'd2: src = cur.de[15:8];
      3'd3: src = cur.de[7:0];
      3'd4: src = cur.hl[15:8];
      3'd5: src = cur.hl[7:0];
      3'd6: src = item.operand_byte;
      default: src = cur.a;
    endcase
    nxt    = cur;
    nxt.pc = pc1;
    st     = '0;
    push   = 1'b0;
    sum    = '0;
    sum16  = '0;
    t8     = '0;
    if (op[7:6] == 2'b01 && op != 8'h76) begin
      case (op[5:3])
        3'd0: nxt.bc[15:8] = src;
        3'd1: nxt.bc[7:0]  = src;
        3'd2: nxt.de[15:8] = src;
        3'd3: nxt.de[7:0]  = src;
        3'd4: nxt.hl[15:8] = src;
        3'd5: nxt.hl[7:0]  = src;
        3'd6: begin
          st.cnt = 2'd1; st.addr = cur.hl; st.lo = src;
        end
        default: nxt.a = src;
      endcase
    end else if (op[7:4] == 4'h8) begin
      sum = {1'b0, cur.a} + {1'b0, src} + {8'd0, op[3] & cur.f[3]};
      nxt.a = sum[7:0];
      nxt.f = c8e_pkg::zsp(sum[7:0], cur.f);
      nxt.f[3] = sum[8];
    end else if (op[7:3] == 5'b10110 || op == 8'hf6) begin
      t8 = cur.a | ((op == 8'hf6) ? item.imm_low : src);
      nxt.a = t8;
      nxt.f = {2'b00, c8e_pkg::even_par(t8), t8[7], (t8 == 8'h00)};
      if (op == 8'hf6) nxt.pc = pc2;
    end else if (op[7:3] == 5'b10111 || op == 8'hfe) begin
      t8  = (op == 8'hfe) ? item.imm_low : src;
      sum = {1'b0, cur.a} - {1'b0, t8};
      nxt.f = c8e_pkg::zsp(sum[7:0], cur.f);
      nxt.f[3] = sum[8];
      if (op == 8'hfe) nxt.pc = pc2;
    end else begin
      case (op)
        8'h00, 8'h08, 8'h76, 8'hf3, 8'hfb: ;
        8'h01: begin nxt.bc = imm16; nxt.pc = pc3; end
        8'h21: begin nxt.hl = imm16; nxt.pc = pc3; end
        8'h31: begin nxt.sp = imm16; nxt.pc = pc3; end
        8'h02: begin st.cnt = 2'd1; st.addr = cur.bc; st.lo = cur.a; end
        8'h32: begin
          st.cnt = 2'd1; st.addr = imm16; st.lo = cur.a; nxt.pc = pc3;
        end
        8'h0a: nxt.a = item.operand_byte;
        8'h3a: begin nxt.a = item.operand_byte; nxt.pc = pc3; end
        8'h03: nxt.bc = cur.bc + 16'd1;
        8'h0b: nxt.bc = cur.bc - 16'd1;
        8'h33: nxt.sp = cur.sp + 16'd1;
        8'h3b: nxt.sp = cur.sp - 16'd1;
        8'h04: begin t8 = cur.bc[15:8] + 8'd1; nxt.bc[15:8] = t8;
          nxt.f = c8e_pkg::zsp(t8, cur.f); end
        8'h05: begin t8 = cur.bc[15:8] - 8'd1; nxt.bc[15:8] = t8;
          nxt.f = c8e_pkg::zsp(t8, cur.f); end
        8'h0c: begin t8 = cur.bc[7:0] + 8'd1; nxt.bc[7:0] = t8;
          nxt.f = c8e_pkg::zsp(t8, cur.f); end
        8'h0d: begin t8 = cur.bc[7:0] - 8'd1; nxt.bc[7:0] = t8;
          nxt.f = c8e_pkg::zsp(t8, cur.f); end
        8'h3c: begin t8 = cur.a + 8'd1; nxt.a = t8;
          nxt.f = c8e_pkg::zsp(t8, cur.f); end
        8'h3d: begin t8 = cur.a - 8'd1; nxt.a = t8;
          nxt.f = c8e_pkg::zsp(t8, cur.f); end
        8'h34, 8'h35: begin
          t8 = op[0] ? item.operand_byte - 8'd1 : item.operand_byte + 8'd1;
          nxt.f = c8e_pkg::zsp(t8, cur.f);
          st.cnt = 2'd1; st.addr = cur.hl; st.lo = t8;
        end
        8'h06: begin nxt.bc[15:8] = item.imm_low; nxt.pc = pc2; end
        8'h0e: begin nxt.bc[7:0] = item.imm_low; nxt.pc = pc2; end
        8'h3e: begin nxt.a = item.imm_low; nxt.pc = pc2; end
        8'h36: begin
          st.cnt = 2'd1; st.addr = cur.hl; st.lo = item.imm_low; nxt.pc = pc2;
        end
        8'h07: begin nxt.f[3] = cur.a[7]; nxt.a = {cur.a[6:0], cur.a[7]}; end
        8'h0f: begin nxt.f[3] = cur.a[0]; nxt.a = {cur.a[0], cur.a[7:1]}; end
        8'h09, 8'h39: begin
          sum16 = {1'b0, cur.hl} + {1'b0, (op == 8'h09) ? cur.bc : cur.sp};
          nxt.hl = sum16[15:0];
          nxt.f[3] = sum16[16];
        end
        8'h37: nxt.f[3] = 1'b1;
        8'h3f: nxt.f[3] = ~cur.f[3];
        8'hf0, 8'hf8: begin
          if ((op == 8'hf0) == pos) begin
            nxt.pc = stk; nxt.sp = cur.sp + 16'd2;
          end
        end
        8'hf1: begin
          nxt.a = item.stack_high; nxt.f = item.stack_low[4:0];
          nxt.sp = cur.sp + 16'd2;
        end
        8'hf2, 8'hfa: nxt.pc = ((op == 8'hf2) == pos) ? imm16 : pc3;
        8'hf4, 8'hfc: begin
          nxt.pc = pc3;
          if ((op == 8'hf4) == pos) begin
            st.lo = pc3[7:0]; st.hi = pc3[15:8]; push = 1'b1; nxt.pc = imm16;
          end
        end
        8'hf5: begin st.lo = {3'b000, cur.f}; st.hi = cur.a; push = 1'b1; end
        8'hf7, 8'hff: begin
          st.lo = pc1[7:0]; st.hi = pc1[15:8]; push = 1'b1;
          nxt.pc = (op == 8'hf7) ? c8e_pkg::RST6_VEC : c8e_pkg::RST7_VEC;
        end
        8'hf9: nxt.sp = cur.hl;
        default: begin
          nxt = cur;
          st.unimp = 1'b1;
        end
      endcase
    end
    if (push) begin
      nxt.sp  = sp_dn;
      st.cnt  = 2'd2;
      st.addr = sp_dn;
    end
  end

endmodule

FILE: hdl/c8e_store_gate.sv
// ----------------------------------------------------------------------------
// c8e_store_gate
// Window check on the store request and status encode.
// ----------------------------------------------------------------------------
module c8e_store_gate (
  input  c8e_pkg::store_t st,
  input  logic [15:0]     ram_low,
  input  logic [15:0]     ram_high,
  output logic [1:0]      cnt,
  output logic [15:0]     addr,
  output logic [7:0]      lo,
  output logic [7:0]      hi,
  output logic [1:0]      status
);

  logic [15:0] addr1;
  logic        ok0, ok1, ok;

  always_comb begin
    addr1 = st.addr + 16'd1;
    ok0   = (ram_low <= st.addr) && (st.addr <= ram_high);
    ok1   = (ram_low <= addr1) && (addr1 <= ram_high);
    ok    = ok0 && ((st.cnt != 2'd2) || ok1);
    cnt = st.cnt; addr = st.addr; lo = st.lo; hi = st.hi;
    status = st.unimp ? c8e_pkg::ST_UNIMP : c8e_pkg::ST_OK;
    if (st.cnt != 2'd0 && !ok) begin
      cnt = '0; addr = '0; lo = '0; hi = '0;
      status = c8e_pkg::ST_WIN;
    end
  end

endmodule

FILE: hdl/cpu8080_execute_subset_core.sv
// ----------------------------------------------------------------------------
// cpu8080_execute_subset_core
// One 8080 instruction per request against internal A, BC, DE, HL, SP, PC, F.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per instruction: opcode, two immediate bytes, the
//           memory byte at the effective address and the two stack bytes.
//   out_* : one result per request: new PC, SP, registers, flags, and up to
//           two store bytes (write_count), gated by the write window.
//   cfg_* : write ram_low (index 0) or ram_high (index 1) while idle.
// Timing: the result of an accepted request is registered onto out_* as the
//   request is accepted; one request per cycle sustained while out_ready holds,
//   set by the single output register that holds the result.
// The architectural state updates when the request is accepted, so the next
//   request executes against it at once.
// Stall: while out_valid is high and out_ready low, the result holds and
//   in_ready drops; a result taken in the same cycle frees room for the next.
// Reset: all registers, SP, PC and flags clear; window returns to
//   0x2000..0x3FFF; out_valid drops.
// ----------------------------------------------------------------------------
module cpu8080_execute_subset_core #(
  parameter logic [15:0] RAM_LOW_INIT  = c8e_pkg::RAM_LOW_RST,
  parameter logic [15:0] RAM_HIGH_INIT = c8e_pkg::RAM_HIGH_RST
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  c8e_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output c8e_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  c8e_pkg::arch_t     arch_r, arch_nxt;
  c8e_pkg::store_t    st;
  c8e_pkg::out_item_t out_r, out_nxt;
  logic               out_valid_r;
  logic [15:0]        ram_low_r, ram_high_r;
  logic               take;

  assign in_ready  = !out_valid_r || out_ready;
  assign take      = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  c8e_exec u_exec (
    .item (in_data),
    .cur  (arch_r),
    .nxt  (arch_nxt),
    .st   (st)
  );

  c8e_store_gate u_gate (
    .st       (st),
    .ram_low  (ram_low_r),
    .ram_high (ram_high_r),
    .cnt      (out_nxt.write_count),
    .addr     (out_nxt.write_addr),
    .lo       (out_nxt.write_low),
    .hi       (out_nxt.write_high),
    .status   (out_nxt.status)
  );

  // Result fields straight from the updated state.
  assign out_nxt.next_pc   = arch_nxt.pc;
  assign out_nxt.stack_ptr = arch_nxt.sp;
  assign out_nxt.acc_out   = arch_nxt.a;
  assign out_nxt.pair_bc   = arch_nxt.bc;
  assign out_nxt.pair_de   = arch_nxt.de;
  assign out_nxt.pair_hl   = arch_nxt.hl;
  assign out_nxt.flag_bits = arch_nxt.f;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arch_r      <= '0;
      out_valid_r <= 1'b0;
      ram_low_r   <= RAM_LOW_INIT;
      ram_high_r  <= RAM_HIGH_INIT;
    end else begin
      // Advance state and load the result on each accepted request.
      if (take) begin
        arch_r <= arch_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          c8e_pkg::CFG_RAM_LOW:  ram_low_r  <= cfg_data;
          c8e_pkg::CFG_RAM_HIGH: ram_high_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= out_nxt;
    end
  end

endmodule

FILE: hdl/c8e_checker.sv
// ----------------------------------------------------------------------------
// c8e_checker
// Port-level checks on the execute core, bound to the top level.
// ----------------------------------------------------------------------------
`include "cpu8080_execute_subset_core_assert.svh"

module c8e_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input c8e_pkg::out_item_t out_data
);

  `C8E_ASSERT_NEXT(a_res_follows, clk, rst_n, in_valid && in_ready, out_valid,
    "accepted request gave no result")
  `C8E_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, $stable(out_data),
    "stalled result changed")
  `C8E_ASSERT_IMPL(a_ready, clk, rst_n, out_valid && !out_ready, !in_ready,
    "request taken while result stalled")
  `C8E_ASSERT_IMPL(a_win, clk, rst_n, out_valid && out_data.status == c8e_pkg::ST_WIN,
    out_data.write_count == 2'd0, "suppressed store still counted")
  `C8E_ASSERT_IMPL(a_unimp, clk, rst_n,
    out_valid && out_data.status == c8e_pkg::ST_UNIMP,
    out_data.write_count == 2'd0, "unimplemented opcode stored")

endmodule

bind cpu8080_execute_subset_core c8e_checker u_c8e_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: dv/tb_cpu8080_execute_subset_core.sv
// ----------------------------------------------------------------------------
// tb_cpu8080_execute_subset_core
// Self-checking regression for the 8080 execute subset core. A behavioral
// model of the instruction subset tracks A, BC, DE, HL, SP, PC and flags,
// predicts each result and compares it field by field with the block output
// under random sender gaps and receiver stalls and several write windows.
// ----------------------------------------------------------------------------
module tb_cpu8080_execute_subset_core;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  c8e_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  c8e_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [0:0]         cfg_index = c8e_pkg::CFG_RAM_LOW;
  logic [15:0]        cfg_data = '0;

  cpu8080_execute_subset_core dut (.*);

  always #5 clk = ~clk;

  // Model state, kept in step with the block.
  logic [7:0]  m_a;
  logic [7:0]  m_r [6];
  logic [15:0] m_sp, m_pc, m_low, m_high;
  logic [4:0]  m_f;

  c8e_pkg::out_item_t expected_q[$];
  int        errors = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;
  longint    cycles = 0;
  localparam longint CYCLE_LIMIT = 1000000;

  // Abort on runaway.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("cpu8080_execute_subset_core regression: fail");
      $finish;
    end
  end

  function automatic logic [4:0] flags_zsp(input logic [7:0] v, input logic [4:0] f);
    logic [4:0] r;
    r = f & 5'h18;
    r[0] = (v == 8'h00);
    r[1] = v[7];
    r[2] = ~^v;
    return r;
  endfunction

  function automatic logic [7:0] source_byte(input logic [2:0] code, input logic [7:0] mem);
    if (code == 3'd6) return mem;
    if (code == 3'd7) return m_a;
    return m_r[code];
  endfunction

  function automatic logic fits_window(input logic [15:0] addr);
    return (m_low <= addr) && (addr <= m_high);
  endfunction

  // Execute one instruction on the model state and return the result.
  function automatic c8e_pkg::out_item_t execute_instr(input c8e_pkg::in_item_t it);
    c8e_pkg::out_item_t o;
    logic [7:0] op, lo, v, b;
    logic [15:0] npc, sp, imm16, hl, bc, stk;
    logic [16:0] w;
    logic [8:0] s;
    logic [1:0] wc;
    logic [15:0] waddr;
    logic [7:0] wlo, whi;
    logic impl, pos, push, ok;
    logic [2:0] d;
    op = it.opcode; lo = it.imm_low;
    imm16 = {it.imm_high, it.imm_low};
    stk = {it.stack_high, it.stack_low};
    sp = m_sp; npc = m_pc + 16'd1;
    hl = {m_r[4], m_r[5]}; bc = {m_r[0], m_r[1]};
    wc = 2'd0; waddr = '0; wlo = '0; whi = '0;
    o = '0; o.status = c8e_pkg::ST_OK;
    impl = 1'b1; push = 1'b0; pos = ~m_f[1];
    if (op >= 8'h40 && op <= 8'h7f && op != 8'h76) begin
      d = op[5:3]; v = source_byte(op[2:0], it.operand_byte);
      if (d == 3'd6) begin
        wc = 2'd1; waddr = hl; wlo = v;
      end else if (d == 3'd7) m_a = v;
      else m_r[d] = v;
    end else if (op >= 8'h80 && op <= 8'h8f) begin
      s = {1'b0, m_a} + source_byte(op[2:0], it.operand_byte);
      if (op >= 8'h88 && m_f[3]) s = s + 9'd1;
      m_f = flags_zsp(s[7:0], m_f); m_f[3] = s[8];
      m_a = s[7:0];
    end else if ((op >= 8'hb0 && op <= 8'hb7) || op == 8'hf6) begin
      m_a = m_a | ((op == 8'hf6) ? lo : source_byte(op[2:0], it.operand_byte));
      m_f = flags_zsp(m_a, m_f); m_f[3] = 1'b0; m_f[4] = 1'b0;
      if (op == 8'hf6) npc = m_pc + 16'd2;
    end else if ((op >= 8'hb8 && op <= 8'hbf) || op == 8'hfe) begin
      b = (op == 8'hfe) ? lo : source_byte(op[2:0], it.operand_byte);
      m_f = flags_zsp(m_a - b, m_f); m_f[3] = (m_a < b);
      if (op == 8'hfe) npc = m_pc + 16'd2;
    end else begin
      case (op)
        8'h00, 8'h08, 8'h76, 8'hf3, 8'hfb: ;
        8'h01: begin m_r[0] = it.imm_high; m_r[1] = lo; npc = m_pc + 16'd3; end
        8'h21: begin m_r[4] = it.imm_high; m_r[5] = lo; npc = m_pc + 16'd3; end
        8'h31: begin sp = imm16; npc = m_pc + 16'd3; end
        8'h02: begin wc = 2'd1; waddr = bc; wlo = m_a; end
        8'h32: begin wc = 2'd1; waddr = imm16; wlo = m_a; npc = m_pc + 16'd3; end
        8'h0a: m_a = it.operand_byte;
        8'h3a: begin m_a = it.operand_byte; npc = m_pc + 16'd3; end
        8'h03, 8'h0b: begin
          bc = (op == 8'h03) ? bc + 16'd1 : bc - 16'd1;
          {m_r[0], m_r[1]} = bc;
        end
        8'h33: sp = sp + 16'd1;
        8'h3b: sp = sp - 16'd1;
        8'h04, 8'h05, 8'h0c, 8'h0d: begin
          m_r[op[3]] = op[0] ? m_r[op[3]] - 8'd1 : m_r[op[3]] + 8'd1;
          m_f = flags_zsp(m_r[op[3]], m_f);
        end
        8'h3c, 8'h3d: begin
          m_a = op[0] ? m_a - 8'd1 : m_a + 8'd1;
          m_f = flags_zsp(m_a, m_f);
        end
        8'h34, 8'h35: begin
          v = op[0] ? it.operand_byte - 8'd1 : it.operand_byte + 8'd1;
          m_f = flags_zsp(v, m_f); wc = 2'd1; waddr = hl; wlo = v;
        end
        8'h06: begin m_r[0] = lo; npc = m_pc + 16'd2; end
        8'h0e: begin m_r[1] = lo; npc = m_pc + 16'd2; end
        8'h3e: begin m_a = lo; npc = m_pc + 16'd2; end
        8'h36: begin wc = 2'd1; waddr = hl; wlo = lo; npc = m_pc + 16'd2; end
        8'h07: begin m_f[3] = m_a[7]; m_a = {m_a[6:0], m_a[7]}; end
        8'h0f: begin m_f[3] = m_a[0]; m_a = {m_a[0], m_a[7:1]}; end
        8'h09, 8'h39: begin
          w = {1'b0, hl} + ((op == 8'h09) ? bc : sp);
          {m_r[4], m_r[5]} = w[15:0]; m_f[3] = w[16];
        end
        8'h37: m_f[3] = 1'b1;
        8'h3f: m_f[3] = ~m_f[3];
        8'hf0, 8'hf8: if ((op == 8'hf0) == pos) begin
          npc = stk; sp = sp + 16'd2;
        end
        8'hf1: begin m_a = stk[15:8]; m_f = stk[4:0]; sp = sp + 16'd2; end
        8'hf2, 8'hfa: npc = ((op == 8'hf2) == pos) ? imm16 : m_pc + 16'd3;
        8'hf4, 8'hfc: begin
          npc = m_pc + 16'd3;
          if ((op == 8'hf4) == pos) begin
            {whi, wlo} = npc; push = 1'b1; npc = imm16;
          end
        end
        8'hf5: begin wlo = {3'b0, m_f}; whi = m_a; push = 1'b1; end
        8'hf7, 8'hff: begin
          {whi, wlo} = npc; push = 1'b1;
          npc = (op == 8'hf7) ? c8e_pkg::RST6_VEC : c8e_pkg::RST7_VEC;
        end
        8'hf9: sp = hl;
        default: impl = 1'b0;
      endcase
    end
    if (push) begin
      sp = sp - 16'd2; wc = 2'd2; waddr = sp;
    end
    if (!impl) begin
      npc = m_pc; o.status = c8e_pkg::ST_UNIMP;
    end
    if (wc != 2'd0) begin
      ok = fits_window(waddr);
      if (wc == 2'd2 && !fits_window(waddr + 16'd1)) ok = 1'b0;
      if (!ok) begin
        wc = 2'd0; waddr = '0; wlo = '0; whi = '0; o.status = c8e_pkg::ST_WIN;
      end
    end
    m_pc = npc; m_sp = sp;
    o.next_pc = npc; o.stack_ptr = sp; o.acc_out = m_a;
    o.pair_bc = {m_r[0], m_r[1]}; o.pair_de = {m_r[2], m_r[3]};
    o.pair_hl = {m_r[4], m_r[5]}; o.flag_bits = m_f;
    o.write_count = wc; o.write_addr = waddr; o.write_low = wlo;
    o.write_high = whi;
    return o;
  endfunction

  // Receiver: stall at random, compare every taken result with the oldest
  // prediction.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    c8e_pkg::out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result, next_pc %h", out_data.next_pc);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_data.next_pc !== e.next_pc) begin
          $error("next_pc exp %h got %h", e.next_pc, out_data.next_pc); errors++;
        end
        if (out_data.stack_ptr !== e.stack_ptr) begin
          $error("stack_ptr exp %h got %h", e.stack_ptr, out_data.stack_ptr); errors++;
        end
        if (out_data.acc_out !== e.acc_out) begin
          $error("acc_out exp %h got %h", e.acc_out, out_data.acc_out); errors++;
        end
        if (out_data.pair_bc !== e.pair_bc) begin
          $error("pair_bc exp %h got %h", e.pair_bc, out_data.pair_bc); errors++;
        end
        if (out_data.pair_de !== e.pair_de) begin
          $error("pair_de exp %h got %h", e.pair_de, out_data.pair_de); errors++;
        end
        if (out_data.pair_hl !== e.pair_hl) begin
          $error("pair_hl exp %h got %h", e.pair_hl, out_data.pair_hl); errors++;
        end
        if (out_data.flag_bits !== e.flag_bits) begin
          $error("flag_bits exp %h got %h", e.flag_bits, out_data.flag_bits); errors++;
        end
        if (out_data.write_count !== e.write_count) begin
          $error("write_count exp %h got %h", e.write_count, out_data.write_count);
          errors++;
        end
        if (out_data.write_addr !== e.write_addr) begin
          $error("write_addr exp %h got %h", e.write_addr, out_data.write_addr); errors++;
        end
        if (out_data.write_low !== e.write_low) begin
          $error("write_low exp %h got %h", e.write_low, out_data.write_low); errors++;
        end
        if (out_data.write_high !== e.write_high) begin
          $error("write_high exp %h got %h", e.write_high, out_data.write_high); errors++;
        end
        if (out_data.status !== e.status) begin
          $error("status exp %h got %h", e.status, out_data.status); errors++;
        end
      end
    end
  end

  // Send one request; the prediction is queued at the accepting edge. Valid
  // stays high into the next request unless the sender idles.
  task automatic send_instr(input logic [7:0] op, input logic [7:0] lo, input logic [7:0] hi,
                            input logic [7:0] mem, input logic [7:0] sl, input logic [7:0] sh);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{op, lo, hi, mem, sl, sh};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(execute_instr(in_data));
    @(negedge clk);
  endtask

  task automatic send_random(input logic [7:0] op);
    send_instr(op, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Drop valid, wait for all results, then idle for slack before a register
  // write.
  task automatic drain;
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [0:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == c8e_pkg::CFG_RAM_LOW) m_low = val; else m_high = val;
    @(negedge clk);
  endtask

  task automatic set_window(input logic [15:0] lo, input logic [15:0] hi);
    drain();
    write_cfg(c8e_pkg::CFG_RAM_LOW, lo);
    write_cfg(c8e_pkg::CFG_RAM_HIGH, hi);
    cfg_valid <= 1'b0;
  endtask

  // Directed: field extremes, pushes near the window edges, unimplemented.
  task automatic test_directed;
    send_instr(8'h31, 8'h00, 8'h20, 8'h00, 8'h00, 8'h00); // SP at window low
    send_instr(8'hf5, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00); // push drops below window
    send_instr(8'h21, 8'hff, 8'h3f, 8'h00, 8'h00, 8'h00); // HL at window top
    send_instr(8'h36, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00);
    send_instr(8'h34, 8'h00, 8'h00, 8'hff, 8'h00, 8'h00); // INR M wraps to zero
    send_instr(8'h35, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_instr(8'h3e, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00);
    send_instr(8'h87, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00); // carry out
    send_instr(8'h8f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00); // with carry in
    send_instr(8'hfe, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00);
    send_instr(8'h31, 8'h01, 8'h40, 8'h00, 8'h00, 8'h00); // push straddles top edge
    send_instr(8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_instr(8'hf1, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff); // POP PSW, high bits ignored
    send_instr(8'hf8, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff); // RM taken
    send_instr(8'hfc, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00);
    send_instr(8'h31, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00); // SP wraps on push
    send_instr(8'hf7, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_instr(8'h39, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_instr(8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00); // unimplemented
    send_instr(8'h27, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_instr(8'hf9, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_instr(8'hf0, 8'h34, 8'h12, 8'h00, 8'h00, 8'h00);
    send_instr(8'hf2, 8'h34, 8'h12, 8'h00, 8'h00, 8'h00);
  endtask

  // Random mix: mostly opcodes that do something, plus any byte at all. Point
  // HL, BC and SP into the window often so stores land.
  task automatic test_random(input int count);
    logic [7:0] op;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: op = 8'($urandom);
        1: op = 8'h21;
        2: op = 8'h31;
        3: op = 8'h01;
        default: begin
          op = 8'($urandom);
          while (op inside {8'h10, 8'h18, 8'h20, 8'h28, 8'h30, 8'h38}) op = 8'($urandom);
        end
      endcase
      if (op == 8'h21 || op == 8'h31 || op == 8'h01)
        send_instr(op, 8'($urandom),
                   ($urandom_range(1) != 0) ? 8'h20 + 8'($urandom_range(31)) : 8'($urandom),
                   8'($urandom), 8'($urandom), 8'($urandom));
      else
        send_random(op);
    end
  endtask

  task automatic test_idle_phases;
    int pcts[4][2] = '{'{0, 0}, '{70, 0}, '{0, 70}, '{33, 33}};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = pcts[p][0]; stall_pct = pcts[p][1];
      test_random(280);
    end
    send_idle_pct = 0; stall_pct = 0;
  endtask

  // Windows: full space, empty (low above high), one byte, top edge.
  task automatic test_windows;
    set_window(16'h0000, 16'hffff); test_random(120);
    set_window(16'hffff, 16'h0000); test_random(60);
    set_window(16'h2000, 16'h2000); test_random(60);
    set_window(16'hff00, 16'hffff); test_random(60);
    set_window(16'h2000, 16'h3fff);
  endtask

  initial begin
    m_a = '0; m_sp = '0; m_pc = '0; m_f = '0;
    foreach (m_r[i]) m_r[i] = '0;
    m_low = c8e_pkg::RAM_LOW_RST; m_high = c8e_pkg::RAM_HIGH_RST;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_idle_phases();
    test_windows();
    drain();
    repeat (10) @(negedge clk);
    if (errors == 0 && expected_q.size() == 0)
      $display("cpu8080_execute_subset_core regression: pass");
    else
      $display("cpu8080_execute_subset_core regression: fail");
    $finish;
  end

endmodule
